### hw/rtl/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// Shared widths and the divider stage record for the segment nearest-point
// pipeline.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int unsigned CoordW = 32;              // Q16.16 coordinate
  localparam int unsigned DiffW  = CoordW + 1;      // coordinate difference
  localparam int unsigned ProdW  = 2 * DiffW;       // product of two differences
  localparam int unsigned LenW   = 2 * CoordW + 1;  // squared length, unsigned
  localparam int unsigned QuoW   = CoordW;          // quotient magnitude
  localparam int unsigned NumW   = LenW + QuoW;     // |delta| * dot
  localparam int unsigned DivSteps = QuoW;

  // which point the answer takes
  typedef enum logic [1:0] {
    SelStart = 2'b01,
    SelEnd   = 2'b10,
    SelProj  = 2'b11
  } cps_sel_e;

  typedef struct packed {
    logic [LenW-1:0]   rem_x;
    logic [LenW-1:0]   rem_y;
    logic [QuoW-1:0]   num_x;    // low dividend bits still to shift in
    logic [QuoW-1:0]   num_y;
    logic [QuoW-1:0]   quo_x;
    logic [QuoW-1:0]   quo_y;
    logic [LenW-1:0]   len;
    logic              neg_x;
    logic              neg_y;
    cps_sel_e          sel;
    logic [CoordW-1:0] ax;
    logic [CoordW-1:0] ay;
    logic [CoordW-1:0] bx;
    logic [CoordW-1:0] by;
  } cps_div_t;

endpackage

### hw/rtl/closest_point_on_segment.sv
// ----------------------------------------------------------------------------
// closest_point_on_segment
// Nearest point of segment A-B to query point P, signed Q16.16.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction enters per cycle when the output is not
// stalled. Six front stages form the differences, the 33x33 products, dot and
// squared length, the case select and the split 32x32 and 32x33 numerator
// products; 32 restoring-division stages (one quotient bit each) then produce
// trunc(|B-A| * dot / len), and a final stage picks A, B or A plus the signed
// offset. Each stage holds its item until the next one frees up, so a stall at
// the output back-fills bubbles before blocking input.
module closest_point_on_segment import cps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CoordW-1:0] point_x_i,
  input  logic [CoordW-1:0] point_y_i,
  input  logic [CoordW-1:0] start_x_i,
  input  logic [CoordW-1:0] start_y_i,
  input  logic [CoordW-1:0] end_x_i,
  input  logic [CoordW-1:0] end_y_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] near_x_o,
  output logic [CoordW-1:0] near_y_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, vo_q;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ldo;
  logic div_rdy [DivSteps+1];
  logic div_vld [DivSteps+1];
  cps_div_t div_dat [DivSteps+1];

  // stage 1: differences
  logic signed [DiffW-1:0] dx1_q, dy1_q, cx1_q, cy1_q;
  logic [CoordW-1:0] ax1_q, ay1_q, bx1_q, by1_q;
  logic degen1_q;
  // stage 2: products
  logic signed [ProdW-1:0] pdx2_q, pdy2_q, pcx2_q, pcy2_q;
  logic signed [DiffW-1:0] cx2_q, cy2_q;
  logic [CoordW-1:0] ax2_q, ay2_q, bx2_q, by2_q;
  logic degen2_q;
  // stage 3: dot and length
  logic signed [ProdW:0] dot3_q;
  logic [LenW-1:0] len3_q;
  logic signed [DiffW-1:0] cx3_q, cy3_q;
  logic [CoordW-1:0] ax3_q, ay3_q, bx3_q, by3_q;
  logic degen3_q;
  // stage 4: select and magnitudes
  cps_sel_e sel4_q, sel4_d;
  logic [LenW-1:0] dot4_q, len4_q;
  logic [QuoW-1:0] mx4_q, my4_q;
  logic nx4_q, ny4_q;
  logic [CoordW-1:0] ax4_q, ay4_q, bx4_q, by4_q;
  logic signed [DiffW-1:0] ncx3, ncy3;
  // stage 5: numerator partial products
  logic [2*QuoW-1:0] plx5_q, ply5_q;
  logic [NumW-QuoW-1:0] phx5_q, phy5_q;
  cps_sel_e sel5_q;
  logic [LenW-1:0] len5_q;
  logic nx5_q, ny5_q;
  logic [CoordW-1:0] ax5_q, ay5_q, bx5_q, by5_q;
  // stage 6: numerator and divider seed
  logic [NumW-1:0] numx5, numy5;
  cps_div_t d6_q, d6_d;

  // -- stage 1
  assign ld1 = !v1_q || ld2;
  assign in_ready_o = ld1;
  always_ff @(posedge clk_i) begin
    if (ld1 && in_valid_i) begin
      dx1_q <= DiffW'($signed(point_x_i)) - DiffW'($signed(start_x_i));
      dy1_q <= DiffW'($signed(point_y_i)) - DiffW'($signed(start_y_i));
      cx1_q <= DiffW'($signed(end_x_i)) - DiffW'($signed(start_x_i));
      cy1_q <= DiffW'($signed(end_y_i)) - DiffW'($signed(start_y_i));
      ax1_q <= start_x_i;
      ay1_q <= start_y_i;
      bx1_q <= end_x_i;
      by1_q <= end_y_i;
      degen1_q <= (start_x_i == end_x_i) && (start_y_i == end_y_i);
    end
  end

  // -- stage 2
  assign ld2 = !v2_q || ld3;
  always_ff @(posedge clk_i) begin
    if (ld2 && v1_q) begin
      pdx2_q <= ProdW'(dx1_q) * ProdW'(cx1_q);
      pdy2_q <= ProdW'(dy1_q) * ProdW'(cy1_q);
      pcx2_q <= ProdW'(cx1_q) * ProdW'(cx1_q);
      pcy2_q <= ProdW'(cy1_q) * ProdW'(cy1_q);
      cx2_q <= cx1_q;
      cy2_q <= cy1_q;
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
      bx2_q <= bx1_q;
      by2_q <= by1_q;
      degen2_q <= degen1_q;
    end
  end

  // -- stage 3
  assign ld3 = !v3_q || ld4;
  always_ff @(posedge clk_i) begin
    if (ld3 && v2_q) begin
      dot3_q <= {pdx2_q[ProdW-1], pdx2_q} + {pdy2_q[ProdW-1], pdy2_q};
      len3_q <= pcx2_q[LenW-1:0] + pcy2_q[LenW-1:0];
      cx3_q <= cx2_q;
      cy3_q <= cy2_q;
      ax3_q <= ax2_q;
      ay3_q <= ay2_q;
      bx3_q <= bx2_q;
      by3_q <= by2_q;
      degen3_q <= degen2_q;
    end
  end

  // -- stage 4
  assign ld4 = !v4_q || ld5;
  assign ncx3 = -cx3_q;
  assign ncy3 = -cy3_q;
  always_comb begin
    if (degen3_q || dot3_q[ProdW]) begin
      sel4_d = SelStart;
    end else if (dot3_q > $signed({2'b00, len3_q})) begin
      sel4_d = SelEnd;
    end else begin
      sel4_d = SelProj;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ld4 && v3_q) begin
      sel4_q <= sel4_d;
      dot4_q <= dot3_q[LenW-1:0];
      len4_q <= len3_q;
      nx4_q  <= cx3_q[DiffW-1];
      ny4_q  <= cy3_q[DiffW-1];
      mx4_q  <= cx3_q[DiffW-1] ? ncx3[QuoW-1:0] : cx3_q[QuoW-1:0];
      my4_q  <= cy3_q[DiffW-1] ? ncy3[QuoW-1:0] : cy3_q[QuoW-1:0];
      ax4_q <= ax3_q;
      ay4_q <= ay3_q;
      bx4_q <= bx3_q;
      by4_q <= by3_q;
    end
  end

  // -- stage 5: |delta| * dot as a 32x32 and a 32x33 partial product
  assign ld5 = !v5_q || ld6;
  always_ff @(posedge clk_i) begin
    if (ld5 && v4_q) begin
      plx5_q <= (2*QuoW)'(mx4_q) * (2*QuoW)'(dot4_q[QuoW-1:0]);
      ply5_q <= (2*QuoW)'(my4_q) * (2*QuoW)'(dot4_q[QuoW-1:0]);
      phx5_q <= (NumW-QuoW)'(mx4_q) * (NumW-QuoW)'(dot4_q[LenW-1:QuoW]);
      phy5_q <= (NumW-QuoW)'(my4_q) * (NumW-QuoW)'(dot4_q[LenW-1:QuoW]);
      sel5_q <= sel4_q;
      len5_q <= len4_q;
      nx5_q <= nx4_q;
      ny5_q <= ny4_q;
      ax5_q <= ax4_q;
      ay5_q <= ay4_q;
      bx5_q <= bx4_q;
      by5_q <= by4_q;
    end
  end

  // -- stage 6: assemble numerator, seed remainder with its upper bits
  assign ld6 = !v6_q || div_rdy[0];
  assign numx5 = NumW'(plx5_q) + {phx5_q, {QuoW{1'b0}}};
  assign numy5 = NumW'(ply5_q) + {phy5_q, {QuoW{1'b0}}};
  always_comb begin
    d6_d.rem_x = numx5[NumW-1:QuoW];
    d6_d.rem_y = numy5[NumW-1:QuoW];
    d6_d.num_x = numx5[QuoW-1:0];
    d6_d.num_y = numy5[QuoW-1:0];
    d6_d.quo_x = '0;
    d6_d.quo_y = '0;
    d6_d.len   = len5_q;
    d6_d.neg_x = nx5_q;
    d6_d.neg_y = ny5_q;
    d6_d.sel   = sel5_q;
    d6_d.ax    = ax5_q;
    d6_d.ay    = ay5_q;
    d6_d.bx    = bx5_q;
    d6_d.by    = by5_q;
  end
  always_ff @(posedge clk_i) begin
    if (ld6 && v5_q) begin
      d6_q <= d6_d;
    end
  end

  // -- valid bits of the front stages and the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
      if (ld5) v5_q <= v4_q;
      if (ld6) v6_q <= v5_q;
      if (ldo) vo_q <= div_vld[DivSteps];
    end
  end

  // -- division chain
  assign div_vld[0] = v6_q;
  assign div_dat[0] = d6_q;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    cps_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_vld[g]),
      .in_ready_o  (div_rdy[g]),
      .in_data_i   (div_dat[g]),
      .out_valid_o (div_vld[g+1]),
      .out_ready_i (div_rdy[g+1]),
      .out_data_o  (div_dat[g+1])
    );
  end

  // -- output stage
  cps_div_t        df;
  logic [QuoW-1:0] offx, offy;
  logic [CoordW-1:0] nearx_q, neary_q, nearx_d, neary_d;

  assign ldo = !vo_q || out_ready_i;
  assign div_rdy[DivSteps] = ldo;
  assign df = div_dat[DivSteps];
  assign offx = df.neg_x ? -df.quo_x : df.quo_x;
  assign offy = df.neg_y ? -df.quo_y : df.quo_y;

  always_comb begin
    case (df.sel)
      SelStart: begin
        nearx_d = df.ax;
        neary_d = df.ay;
      end
      SelEnd: begin
        nearx_d = df.bx;
        neary_d = df.by;
      end
      SelProj: begin
        nearx_d = df.ax + offx;
        neary_d = df.ay + offy;
      end
      default: begin
        nearx_d = df.ax;
        neary_d = df.ay;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ldo && div_vld[DivSteps]) begin
      nearx_q <= nearx_d;
      neary_q <= neary_d;
    end
  end

  assign out_valid_o = vo_q;
  assign near_x_o    = nearx_q;
  assign near_y_o    = neary_q;

endmodule

### hw/rtl/cps_div_step.sv
// ----------------------------------------------------------------------------
// cps_div_step
// One registered restoring-division step for both coordinates.
// ----------------------------------------------------------------------------
module cps_div_step import cps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cps_div_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cps_div_t out_data_o
);

  logic     valid_q;
  cps_div_t data_q, data_d;
  logic     load;

  logic [LenW:0]   shx, shy;
  logic [LenW+1:0] dfx, dfy;
  logic            gex, gey;

  assign load       = !valid_q || out_ready_i;
  assign in_ready_o = load;

  always_comb begin
    shx = {in_data_i.rem_x, in_data_i.num_x[QuoW-1]};
    shy = {in_data_i.rem_y, in_data_i.num_y[QuoW-1]};
    dfx = {1'b0, shx} - {2'b00, in_data_i.len};
    dfy = {1'b0, shy} - {2'b00, in_data_i.len};
    gex = !dfx[LenW+1];
    gey = !dfy[LenW+1];
    data_d       = in_data_i;
    data_d.rem_x = gex ? dfx[LenW-1:0] : shx[LenW-1:0];
    data_d.rem_y = gey ? dfy[LenW-1:0] : shy[LenW-1:0];
    data_d.num_x = {in_data_i.num_x[QuoW-2:0], 1'b0};
    data_d.num_y = {in_data_i.num_y[QuoW-2:0], 1'b0};
    data_d.quo_x = {in_data_i.quo_x[QuoW-2:0], gex};
    data_d.quo_y = {in_data_i.quo_y[QuoW-2:0], gey};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### hw/rtl/cps_checker.sv
// ----------------------------------------------------------------------------
// cps_checker
// Port-level checks for the nearest-point pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module cps_checker import cps_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CoordW-1:0] near_x_o,
  input logic [CoordW-1:0] near_y_o
);

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(near_x_o) && $stable(near_y_o))
    else $error("result changed while stalled");

  // an empty output stage means the pipe can always take a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // a draining output never backs up into the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output drains");

  // nothing comes out right after reset
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind closest_point_on_segment cps_checker u_cps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .near_x_o    (near_x_o),
  .near_y_o    (near_y_o)
);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for closest_point_on_segment: directed corner cases and
// random segment queries under three idle profiles, checked against a
// wide-arithmetic nearest-point predictor through a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cps_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CoordW-1:0] point_x_i = '0, point_y_i = '0;
  logic [CoordW-1:0] start_x_i = '0, start_y_i = '0;
  logic [CoordW-1:0] end_x_i = '0, end_y_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CoordW-1:0] near_x_o, near_y_o;

  int unsigned errors = 0;
  int unsigned src_idle = 38, snk_idle = 81;
  bit          hold_off = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  closest_point_on_segment dut (.*);

  class nearest_sb;
    logic [2*CoordW-1:0] pending[$];

    function automatic logic [2*CoordW-1:0] nearest(
        logic signed [31:0] px, logic signed [31:0] py,
        logic signed [31:0] ax, logic signed [31:0] ay,
        logic signed [31:0] bx, logic signed [31:0] by);
      logic signed [32:0]  dx, dy, cx, cy;
      logic signed [127:0] dot, len, qx, qy;
      logic [31:0]         rx, ry;
      dx = {px[31], px} - {ax[31], ax};
      dy = {py[31], py} - {ay[31], ay};
      cx = {bx[31], bx} - {ax[31], ax};
      cy = {by[31], by} - {ay[31], ay};
      dot = dx * cx + dy * cy;
      len = cx * cx + cy * cy;
      if (ax == bx && ay == by) begin
        rx = ax; ry = ay;
      end else if (dot < 0) begin
        rx = ax; ry = ay;
      end else if (dot > len) begin
        rx = bx; ry = by;
      end else begin
        // signed division truncates toward zero
        qx = (cx * dot) / len;
        qy = (cy * dot) / len;
        rx = ax + qx[31:0];
        ry = ay + qy[31:0];
      end
      return {rx, ry};
    endfunction

    function void note(logic [31:0] px, logic [31:0] py, logic [31:0] ax,
                       logic [31:0] ay, logic [31:0] bx, logic [31:0] by);
      pending = {pending, nearest(px, py, ax, ay, bx, by)};
    endfunction

    function bit check(logic [31:0] x, logic [31:0] y, output string why);
      logic [2*CoordW-1:0] exp_xy;
      if (pending.size() == 0) begin
        why = $sformatf("unexpected result x=%h y=%h", x, y);
        return 1'b0;
      end
      exp_xy = pending.pop_front();
      if (exp_xy[63:32] !== x || exp_xy[31:0] !== y) begin
        why = $sformatf("near got %h,%h exp %h,%h", x, y, exp_xy[63:32], exp_xy[31:0]);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  nearest_sb sb = new();

  task automatic report(string why);
    errors++;
    $display("%0t mismatch: %s", $realtime, why);
  endtask

  // drive one transaction, starting at a falling edge
  task automatic send(logic [31:0] px, logic [31:0] py, logic [31:0] ax,
                      logic [31:0] ay, logic [31:0] bx, logic [31:0] by);
    point_x_i = px; point_y_i = py;
    start_x_i = ax; start_y_i = ay;
    end_x_i = bx;   end_y_i = by;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(px, py, ax, ay, bx, by);
    @(negedge clk_i);
    if ($urandom_range(99) < src_idle) begin
      in_valid_i = 1'b0;
      while ($urandom_range(99) < src_idle) @(negedge clk_i);
      @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_coord(int unsigned kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(40)) - 20) <<< 16;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom() >>> $urandom_range(31);
    endcase
  endfunction

  task automatic send_random();
    logic [31:0] ax, ay, bx, by, px, py;
    int unsigned k;
    k = $urandom_range(3);
    ax = rand_coord(k); ay = rand_coord(k);
    bx = rand_coord(k); by = rand_coord(k);
    if ($urandom_range(9) == 0) begin
      bx = ax; by = ay;
    end else if ($urandom_range(9) == 0) begin
      bx = ax + $urandom_range(3); by = ay - $urandom_range(1);
    end
    if ($urandom_range(2) == 0) begin
      px = rand_coord($urandom_range(3)); py = rand_coord($urandom_range(3));
    end else begin
      px = ax + rand_coord(2); py = ay + rand_coord(2);
    end
    send(px, py, ax, ay, bx, by);
  endtask

  // output side: random stalls, plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_off) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk_i) begin
    string why;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (!sb.check(near_x_o, near_y_o, why)) report(why);
    end
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    localparam logic [31:0] MaxC = 32'h7fff_ffff;
    localparam logic [31:0] MinC = 32'h8000_0000;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners
    send(0, 0, 0, 0, 0, 0);
    send(MaxC, MinC, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000);
    send(32'hffff_0000, 0, 0, 0, 32'h0001_0000, 0);           // behind start
    send(32'h0005_0000, 0, 0, 0, 32'h0001_0000, 0);           // beyond end
    send(32'h0000_8000, 32'h0003_0000, 0, 0, 32'h0001_0000, 0);
    send(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0003_0000, 32'h0007_0000);
    send(MaxC, MaxC, MinC, MinC, MaxC, MaxC);
    send(MinC, MinC, MinC, MinC, MaxC, MaxC);
    send(0, 0, MinC, MinC, MaxC, MaxC);
    send(MinC, MaxC, MaxC, MinC, MinC, MaxC);
    send(0, MaxC, MaxC, 0, MinC, 0);
    send(MaxC, MinC, MinC, MaxC, MaxC, MinC);
    send(1, 0, 0, 0, 1, 0);
    send(0, 1, 0, 0, 3, 1);
    send(32'hffff_ffff, 32'hffff_ffff, 0, 0, 32'h0000_0007, 32'hffff_fffd);
    send(0, 0, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff);
    send(32'h1234_5678, 32'h9abc_def0, MaxC, 0, MaxC, 1);
    send(MinC, MinC, MaxC, MaxC, MaxC, MaxC);

    repeat (330) send_random();
    src_idle = 81; snk_idle = 38;
    repeat (330) send_random();
    src_idle = 0; snk_idle = 0;
    // long output stall so the pipeline fills and blocks the input
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (340) send_random();
    join
    in_valid_i = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
